// File: design/afv_pkg.sv
// Shared constants, types and helper functions of the ABC flow voxel generator.
`timescale 1ns / 1ps

package afv_pkg;

    localparam int COORD_W     = 10;
    localparam int SIDE_W      = 11;
    localparam int PHASE_W     = 12;
    localparam int ADDR_W      = 30;
    localparam int BYTE_W      = 8;
    localparam int SIN_W       = 15;
    localparam int QTR_W       = 10;
    localparam int QTR_STEPS   = 1024;
    localparam int SUM_W       = 20;
    localparam int ROOT_W      = 16;
    localparam int SQ_NUM_W    = 32;
    localparam int SQ_REM_W    = 18;
    localparam int K_W         = 19;
    localparam int MAX_SIDE    = 1024;

    localparam int DIV_STEPS   = COORD_W + PHASE_W;
    localparam int DIV_SPS     = 4;
    localparam int DIV_STAGES  = (DIV_STEPS + DIV_SPS - 1) / DIV_SPS;
    localparam int SQ_IPS      = 4;
    localparam int SQ_STAGES   = ROOT_W / SQ_IPS;
    localparam int SUM_STAGES  = 4;
    localparam int ADDR_STAGE  = 3;
    localparam int LAT         = 1 + DIV_STAGES + 1 + SUM_STAGES + SQ_STAGES + 2;

    localparam logic [SIDE_W-1:0]  SIDE_RESET = 11'd256;
    localparam logic [SIDE_W-1:0]  SIDE_MAX   = 11'd1024;
    localparam logic [SIDE_W-1:0]  SIDE_ONE   = 11'd1;
    localparam logic [PHASE_W-1:0] QTR_PHASE  = 12'd1024;
    localparam logic [QTR_W:0]     QTR_FULL   = 11'd1024;

    localparam logic [K_W-1:0] K_2SQRT3 = 19'd227023;
    localparam logic [K_W-1:0] K_2SQRT2 = 19'd185364;
    localparam logic [K_W-1:0] K_2SQRT6 = 19'd321060;
    localparam logic signed [22:0] SIX_Q16  = 23'sd393216;
    localparam logic signed [22:0] SUM_MAX  = 23'sd1048575;
    localparam logic [49:0]        TERM_RND = 50'd536870912;
    localparam logic signed [17:0] MIN_Q14  = 18'sd51;
    localparam logic signed [42:0] NORM_Q16 = 43'sd4828603;
    localparam logic signed [42:0] BYTE_RND = 43'sd536870912;
    localparam logic [12:0]        BYTE_MAX = 13'd255;

    typedef enum logic [1:0] {
        CFG_SIDE_X = 2'd0,
        CFG_SIDE_Y = 2'd1,
        CFG_SIDE_Z = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                 neg;
        logic [SIN_W-1:0]     mag;
    } t_trig;

    typedef struct packed {
        logic [SIDE_W-1:0]    rem;
        logic [DIV_STEPS-1:0] num;
        logic [PHASE_W-1:0]   quo;
    } t_div;

    typedef struct packed {
        logic [SQ_REM_W-1:0]  rem;
        logic [ROOT_W-1:0]    root;
        logic [SQ_NUM_W-1:0]  num;
    } t_sq;

    typedef logic [SIN_W-1:0] t_qtab [0:QTR_STEPS];

    function automatic t_qtab build_qtab();
        t_qtab             tab;
        longint unsigned   r;
        longint unsigned   th;
        longint unsigned   t2;
        longint unsigned   f;
        longint unsigned   qs;
        longint unsigned   m;
        for (int i = 0; i <= QTR_STEPS; i++) begin
            r  = longint'(i) << 20;
            th = (r * 64'd1686629713) >> 30;
            t2 = (th * th) >> 30;
            f  = 64'd1073741824 - t2 / 110;
            f  = 64'd1073741824 - ((t2 * f) >> 30) / 72;
            f  = 64'd1073741824 - ((t2 * f) >> 30) / 42;
            f  = 64'd1073741824 - ((t2 * f) >> 30) / 20;
            f  = 64'd1073741824 - ((t2 * f) >> 30) / 6;
            qs = (th * f) >> 30;
            m  = (qs + 64'd16384) >> 15;
            if (m > 64'd32767) begin
                m = 64'd32767;
            end
            tab[i] = m[SIN_W-1:0];
        end
        return tab;
    endfunction

    localparam t_qtab QTAB = build_qtab();

    localparam logic [K_W-1:0] FLOW_K [3] = '{K_2SQRT3, K_2SQRT2, K_2SQRT6};

    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] s);
        logic [SIDE_W-1:0] v;
        v = s;
        if (s == '0) begin
            v = SIDE_ONE;
        end else if (s > SIDE_MAX) begin
            v = SIDE_MAX;
        end
        return v;
    endfunction

    function automatic t_div div_stage(input t_div d, input logic [SIDE_W-1:0] side,
                                       input int nsteps);
        t_div             v;
        logic [SIDE_W:0]  rem2;
        logic             qb;
        v = d;
        for (int k = 0; k < DIV_SPS; k++) begin
            if (k < nsteps) begin
                rem2  = {v.rem, v.num[DIV_STEPS-1]};
                v.num = {v.num[DIV_STEPS-2:0], 1'b0};
                qb    = (rem2 >= {1'b0, side});
                if (qb) begin
                    rem2 = rem2 - {1'b0, side};
                end
                v.rem = rem2[SIDE_W-1:0];
                v.quo = {v.quo[PHASE_W-2:0], qb};
            end
        end
        return v;
    endfunction

    function automatic t_sq sq_stage(input t_sq d);
        t_sq                 v;
        logic [SQ_REM_W+1:0] rem4;
        logic [SQ_REM_W+1:0] trial;
        v = d;
        for (int k = 0; k < SQ_IPS; k++) begin
            rem4  = {v.rem, v.num[SQ_NUM_W-1:SQ_NUM_W-2]};
            v.num = {v.num[SQ_NUM_W-3:0], 2'b00};
            trial = {2'b00, v.root, 2'b01};
            if (rem4 >= trial) begin
                rem4   = rem4 - trial;
                v.root = {v.root[ROOT_W-2:0], 1'b1};
            end else begin
                v.root = {v.root[ROOT_W-2:0], 1'b0};
            end
            v.rem = rem4[SQ_REM_W-1:0];
        end
        return v;
    endfunction

endpackage

// File: design/afv_phase_div.sv
// Pipelined restoring divider that turns a coordinate and a side into a phase step.
`timescale 1ns / 1ps

module afv_phase_div (
    input  logic                          i_clk,
    input  logic [afv_pkg::COORD_W-1:0]   i_coord,
    input  logic [afv_pkg::SIDE_W-1:0]    i_side,
    output logic [afv_pkg::PHASE_W-1:0]   o_phase
);

    afv_pkg::t_div r_st [afv_pkg::DIV_STAGES];
    afv_pkg::t_div w_init;

    always_comb begin
        w_init.rem = '0;
        w_init.num = {i_coord, {afv_pkg::PHASE_W{1'b0}}};
        w_init.quo = '0;
    end

    for (genvar g = 0; g < afv_pkg::DIV_STAGES; g++) begin : g_stage
        localparam int NS = (afv_pkg::DIV_STEPS - g * afv_pkg::DIV_SPS < afv_pkg::DIV_SPS) ?
                            (afv_pkg::DIV_STEPS - g * afv_pkg::DIV_SPS) : afv_pkg::DIV_SPS;
        afv_pkg::t_div n_st;
        if (g == 0) begin : g_first
            assign n_st = afv_pkg::div_stage(w_init, i_side, NS);
        end else begin : g_next
            assign n_st = afv_pkg::div_stage(r_st[g-1], i_side, NS);
        end
        always_ff @(posedge i_clk) begin
            r_st[g] <= n_st;
        end
    end

    assign o_phase = r_st[afv_pkg::DIV_STAGES-1].quo;

endmodule

// File: design/afv_sine_lut.sv
// Quarter-wave sine table lookup with registered magnitude and sign.
`timescale 1ns / 1ps

module afv_sine_lut (
    input  logic                          i_clk,
    input  logic [afv_pkg::PHASE_W-1:0]   i_phase,
    output afv_pkg::t_trig                o_val
);

    logic [1:0]                  w_quad;
    logic [afv_pkg::QTR_W:0]     w_low;
    logic [afv_pkg::QTR_W:0]     w_idx;
    afv_pkg::t_trig              r_val;

    always_comb begin
        w_quad = i_phase[afv_pkg::PHASE_W-1:afv_pkg::PHASE_W-2];
        w_low  = {1'b0, i_phase[afv_pkg::QTR_W-1:0]};
        w_idx  = w_quad[0] ? (afv_pkg::QTR_FULL - w_low) : w_low;
    end

    always_ff @(posedge i_clk) begin
        r_val.mag <= afv_pkg::QTAB[w_idx];
        r_val.neg <= w_quad[1];
    end

    assign o_val = r_val;

endmodule

// File: design/afv_flow_sum.sv
// Products of sine and cosine pairs, scaled, rounded and summed into the clamped radicand.
`timescale 1ns / 1ps

module afv_flow_sum (
    input  logic                          i_clk,
    input  afv_pkg::t_trig                i_sin_x,
    input  afv_pkg::t_trig                i_cos_x,
    input  afv_pkg::t_trig                i_sin_y,
    input  afv_pkg::t_trig                i_cos_y,
    input  afv_pkg::t_trig                i_sin_z,
    input  afv_pkg::t_trig                i_cos_z,
    output logic [afv_pkg::SUM_W-1:0]     o_sum
);

    afv_pkg::t_trig              w_s [3];
    afv_pkg::t_trig              w_c [3];
    logic [29:0]                 r_sc   [3];
    logic                        r_neg1 [3];
    logic [48:0]                 r_mk   [3];
    logic                        r_neg2 [3];
    logic signed [20:0]          r_term [3];
    logic [afv_pkg::SUM_W-1:0]   r_sum;
    logic signed [22:0]          n_total;

    assign w_s[0] = i_sin_z;
    assign w_c[0] = i_cos_y;
    assign w_s[1] = i_sin_y;
    assign w_c[1] = i_cos_x;
    assign w_s[2] = i_sin_x;
    assign w_c[2] = i_cos_z;

    for (genvar j = 0; j < 3; j++) begin : g_lane
        logic [49:0] n_rnd;
        logic [19:0] n_q;
        assign n_rnd = {1'b0, r_mk[j]} + afv_pkg::TERM_RND;
        assign n_q   = n_rnd[49:30];
        always_ff @(posedge i_clk) begin
            r_sc[j]   <= 30'(w_s[j].mag * w_c[j].mag);
            r_neg1[j] <= w_s[j].neg ^ w_c[j].neg;
            r_mk[j]   <= 49'(r_sc[j] * afv_pkg::FLOW_K[j]);
            r_neg2[j] <= r_neg1[j];
            r_term[j] <= r_neg2[j] ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});
        end
    end

    always_comb begin
        n_total = afv_pkg::SIX_Q16 + 23'(r_term[0]) + 23'(r_term[1]) + 23'(r_term[2]);
    end

    always_ff @(posedge i_clk) begin
        if (n_total < 0) begin
            r_sum <= '0;
        end else if (n_total > afv_pkg::SUM_MAX) begin
            r_sum <= '1;
        end else begin
            r_sum <= n_total[afv_pkg::SUM_W-1:0];
        end
    end

    assign o_sum = r_sum;

endmodule

// File: design/afv_isqrt.sv
// Pipelined digit-by-digit integer square root of the radicand scaled by 2^12.
`timescale 1ns / 1ps

module afv_isqrt (
    input  logic                          i_clk,
    input  logic [afv_pkg::SUM_W-1:0]     i_sum,
    output logic [afv_pkg::ROOT_W-1:0]    o_root
);

    afv_pkg::t_sq r_st [afv_pkg::SQ_STAGES];
    afv_pkg::t_sq w_init;

    always_comb begin
        w_init.rem  = '0;
        w_init.root = '0;
        w_init.num  = {i_sum, {(afv_pkg::SQ_NUM_W - afv_pkg::SUM_W){1'b0}}};
    end

    for (genvar g = 0; g < afv_pkg::SQ_STAGES; g++) begin : g_stage
        afv_pkg::t_sq n_st;
        if (g == 0) begin : g_first
            assign n_st = afv_pkg::sq_stage(w_init);
        end else begin : g_next
            assign n_st = afv_pkg::sq_stage(r_st[g-1]);
        end
        always_ff @(posedge i_clk) begin
            r_st[g] <= n_st;
        end
    end

    assign o_root = r_st[afv_pkg::SQ_STAGES-1].root;

endmodule

// File: design/abc_flow_voxel_generator_unit.sv
// Top level of the ABC flow voxel generator: address, flow magnitude byte and range flag.
// Throughput is one voxel per cycle while busy is low; the phase dividers and square root are fully pipelined.
// busy is high during reset and in the cycle after it; results cannot be held off by the receiver.
// Synchronous active-low reset clears the valid pipeline and sets all sides to 256.
`timescale 1ns / 1ps

module abc_flow_voxel_generator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [afv_pkg::COORD_W-1:0]   i_coord_x,
    input  logic [afv_pkg::COORD_W-1:0]   i_coord_y,
    input  logic [afv_pkg::COORD_W-1:0]   i_coord_z,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [afv_pkg::SIDE_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    output logic [afv_pkg::ADDR_W-1:0]    o_voxel_address,
    output logic [afv_pkg::BYTE_W-1:0]    o_magnitude_byte,
    output logic                          o_coord_error
);

    localparam int LAT = afv_pkg::LAT;

    logic                          r_busy;
    logic [afv_pkg::SIDE_W-1:0]    r_side_x;
    logic [afv_pkg::SIDE_W-1:0]    r_side_y;
    logic [afv_pkg::SIDE_W-1:0]    r_side_z;
    logic                          r_vld [LAT];
    logic                          r_err [LAT];
    logic [afv_pkg::COORD_W-1:0]   r_cx;
    logic [afv_pkg::COORD_W-1:0]   r_cy;
    logic [afv_pkg::COORD_W-1:0]   r_cz;
    logic [afv_pkg::COORD_W-1:0]   r_a1_cx;
    logic [afv_pkg::COORD_W-1:0]   r_a1_cz;
    logic [20:0]                   r_sxsy;
    logic [20:0]                   r_cysx;
    logic [30:0]                   r_czsxy;
    logic [21:0]                   r_part;
    logic [afv_pkg::ADDR_W-1:0]    r_addr [afv_pkg::ADDR_STAGE:LAT-1];
    logic signed [42:0]            r_acc;
    logic [afv_pkg::BYTE_W-1:0]    r_byte;
    logic                          w_accept;
    logic [afv_pkg::PHASE_W-1:0]   w_px;
    logic [afv_pkg::PHASE_W-1:0]   w_py;
    logic [afv_pkg::PHASE_W-1:0]   w_pz;
    afv_pkg::t_trig                w_sin_x;
    afv_pkg::t_trig                w_cos_x;
    afv_pkg::t_trig                w_sin_y;
    afv_pkg::t_trig                w_cos_y;
    afv_pkg::t_trig                w_sin_z;
    afv_pkg::t_trig                w_cos_z;
    logic [afv_pkg::SUM_W-1:0]     w_sum;
    logic [afv_pkg::ROOT_W-1:0]    w_root;
    logic signed [17:0]            w_diff;
    logic signed [42:0]            n_acc;
    logic [12:0]                   w_q;
    logic [30:0]                   w_addr_full;

    assign w_accept    = start & ~r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_side_x <= afv_pkg::SIDE_RESET;
            r_side_y <= afv_pkg::SIDE_RESET;
            r_side_z <= afv_pkg::SIDE_RESET;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    afv_pkg::CFG_SIDE_X: r_side_x <= afv_pkg::eff_side(i_cfg_data);
                    afv_pkg::CFG_SIDE_Y: r_side_y <= afv_pkg::eff_side(i_cfg_data);
                    afv_pkg::CFG_SIDE_Z: r_side_z <= afv_pkg::eff_side(i_cfg_data);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= w_accept;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx     <= i_coord_x;
        r_cy     <= i_coord_y;
        r_cz     <= i_coord_z;
        r_err[0] <= ({1'b0, i_coord_x} >= r_side_x) || ({1'b0, i_coord_y} >= r_side_y) ||
                    ({1'b0, i_coord_z} >= r_side_z);
        for (int k = 1; k < LAT; k++) begin
            r_err[k] <= r_err[k-1];
        end
        r_a1_cx <= r_cx;
        r_a1_cz <= r_cz;
        r_sxsy  <= 21'(r_side_x * r_side_y);
        r_cysx  <= 21'(r_cy * r_side_x);
        r_czsxy <= 31'(r_a1_cz * r_sxsy);
        r_part  <= 22'(r_a1_cx) + 22'(r_cysx);
        r_addr[afv_pkg::ADDR_STAGE] <= w_addr_full[afv_pkg::ADDR_W-1:0];
        for (int k = afv_pkg::ADDR_STAGE + 1; k < LAT; k++) begin
            r_addr[k] <= r_addr[k-1];
        end
    end

    assign w_addr_full = r_czsxy + 31'(r_part);

    afv_phase_div u_div_x (.i_clk(i_clk), .i_coord(r_cx), .i_side(r_side_x), .o_phase(w_px));
    afv_phase_div u_div_y (.i_clk(i_clk), .i_coord(r_cy), .i_side(r_side_y), .o_phase(w_py));
    afv_phase_div u_div_z (.i_clk(i_clk), .i_coord(r_cz), .i_side(r_side_z), .o_phase(w_pz));

    afv_sine_lut u_sin_x (.i_clk(i_clk), .i_phase(w_px), .o_val(w_sin_x));
    afv_sine_lut u_cos_x (.i_clk(i_clk), .i_phase(w_px + afv_pkg::QTR_PHASE), .o_val(w_cos_x));
    afv_sine_lut u_sin_y (.i_clk(i_clk), .i_phase(w_py), .o_val(w_sin_y));
    afv_sine_lut u_cos_y (.i_clk(i_clk), .i_phase(w_py + afv_pkg::QTR_PHASE), .o_val(w_cos_y));
    afv_sine_lut u_sin_z (.i_clk(i_clk), .i_phase(w_pz), .o_val(w_sin_z));
    afv_sine_lut u_cos_z (.i_clk(i_clk), .i_phase(w_pz + afv_pkg::QTR_PHASE), .o_val(w_cos_z));

    afv_flow_sum u_sum (
        .i_clk   (i_clk),
        .i_sin_x (w_sin_x),
        .i_cos_x (w_cos_x),
        .i_sin_y (w_sin_y),
        .i_cos_y (w_cos_y),
        .i_sin_z (w_sin_z),
        .i_cos_z (w_cos_z),
        .o_sum   (w_sum)
    );

    afv_isqrt u_sqrt (.i_clk(i_clk), .i_sum(w_sum), .o_root(w_root));

    always_comb begin
        w_diff = $signed({2'b00, w_root}) - afv_pkg::MIN_Q14;
        n_acc  = 43'(w_diff) * afv_pkg::NORM_Q16 + afv_pkg::BYTE_RND;
        w_q    = r_acc[42:30];
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (r_acc < 0) begin
            r_byte <= '0;
        end else if (w_q > afv_pkg::BYTE_MAX) begin
            r_byte <= '1;
        end else begin
            r_byte <= w_q[afv_pkg::BYTE_W-1:0];
        end
    end

    assign o_valid          = r_vld[LAT-1];
    assign o_voxel_address  = r_addr[LAT-1];
    assign o_magnitude_byte = r_byte;
    assign o_coord_error    = r_err[LAT-1];

endmodule
